// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker file atwc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/atwc_pkg.sv -----
package atwc_pkg;

    localparam int UNITS      = 2;
    localparam int UNIT_IDX_W = (UNITS > 1) ? $clog2(UNITS) : 1;

    localparam logic [4:0] DMA_ACCESS_BASE   = 5'd0;
    localparam logic [4:0] DMA_RECOVERY_BASE = 5'd1;
    localparam logic [4:0] DMA_RECOVERY_MIN  = 5'd1;

    localparam logic [31:0] PIO_LEGACY_MASK = 32'h0000_07ff;
    localparam logic [31:0] DMA_LEGACY_MASK = 32'h0fff_f800;
    localparam logic [31:0] PIO_U66_MASK    = 32'he000_03ff;
    localparam logic [31:0] DMA_U66_MASK    = 32'h001f_fc00;
    localparam logic [31:0] UDMA_U66_MASK   = 32'h1ff0_0000;
    localparam logic [31:0] UDMA_SELECT_BIT = 32'h0010_0000;
    localparam logic [9:0]  PS_PER_NS       = 10'd1000;

    localparam int NUM_W  = 23;
    localparam int DEN_W  = 16;
    localparam int CNT_W  = 5;
    localparam int WIDE_W = 41;
    localparam int PROD_W = NUM_W + DEN_W;

    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam logic [1:0] CMD_CALC   = 2'd0;
    localparam logic [1:0] CMD_SELECT = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [1:0] PROTO_PIO  = 2'd0;
    localparam logic [1:0] PROTO_MDMA = 2'd1;
    localparam logic [1:0] PROTO_UDMA = 2'd2;

    localparam logic [1:0] KIND_DMA1  = 2'd0;
    localparam logic [1:0] KIND_DMA2  = 2'd1;
    localparam logic [1:0] KIND_ULTRA = 2'd2;

    localparam logic [3:0] REG_KIND     = 4'd0;
    localparam logic [3:0] REG_SYS_CLK  = 4'd1;
    localparam logic [3:0] REG_U_CLK    = 4'd2;
    localparam logic [3:0] REG_PIO_ABAS = 4'd3;
    localparam logic [3:0] REG_PIO_AMIN = 4'd4;
    localparam logic [3:0] REG_PIO_RBAS = 4'd5;
    localparam logic [3:0] REG_PIO_RMIN = 4'd6;
    localparam logic [3:0] REG_DMA_AMIN = 4'd7;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } div_rsp_t;

    function automatic logic [4:0] sat5(input wide_t v);
        if (v < 0)
            return 5'd0;
        else if (v > 31)
            return 5'd31;
        else
            return v[4:0];
    endfunction

    function automatic logic [5:0] sat6(input wide_t v);
        if (v < 0)
            return 6'd0;
        else if (v > 63)
            return 6'd63;
        else
            return v[5:0];
    endfunction

    function automatic logic [3:0] sat4(input wide_t v);
        if (v < 0)
            return 4'd0;
        else if (v > 15)
            return 4'd15;
        else
            return v[3:0];
    endfunction

endpackage

// ----- rtl/core/ata_timing_word_calculator_core.sv -----
// channel   | dir | handshake        | contents
// s_        | in  | tvalid/tready    | tdata: cmd, unit, protocol, min_access_ns, min_cycle_ns
// m_        | out | tvalid/tready    | tdata: timing_word, ok
// cfg_      | in  | we (no wait)     | index, data
// Calculate beats step through two divisions in the shared restoring divider,
// with a multiply after each and a subtract between them, then the output
// step; other commands and unsupported calculate pairs go straight to the
// output step. One beat is in flight; s_tready is high only when idle.
// A finished result waits in the output register while m_tready is low.
// rst_n is asynchronous, active low; it zeroes the stored words and loads the
// register defaults.
module ata_timing_word_calculator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] cmd, [2] unit, [4:3] protocol, [16:5] min_access_ns,
    // [28:17] min_cycle_ns, [31:29] zero
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] timing_word, [32] ok, [39:33] zero
    output logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import atwc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV1 = 7'b0000010,
        S_MUL1 = 7'b0000100,
        S_SUB  = 7'b0001000,
        S_DIV2 = 7'b0010000,
        S_MUL2 = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [1:0]  kind_reg;
    logic [7:0]  sys_clk_reg;
    logic [15:0] u_clk_reg;
    logic [4:0]  pio_abas_reg, pio_amin_reg, pio_rbas_reg, pio_rmin_reg, dma_amin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= KIND_DMA1;
            sys_clk_reg  <= 8'd30;
            u_clk_reg    <= 16'd7500;
            pio_abas_reg <= 5'd0;
            pio_amin_reg <= 5'd4;
            pio_rbas_reg <= 5'd4;
            pio_rmin_reg <= 5'd1;
            dma_amin_reg <= 5'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KIND:     kind_reg     <= cfg_data[1:0];
                REG_SYS_CLK:  sys_clk_reg  <= cfg_data[7:0];
                REG_U_CLK:    u_clk_reg    <= cfg_data;
                REG_PIO_ABAS: pio_abas_reg <= cfg_data[4:0];
                REG_PIO_AMIN: pio_amin_reg <= cfg_data[4:0];
                REG_PIO_RBAS: pio_rbas_reg <= cfg_data[4:0];
                REG_PIO_RMIN: pio_rmin_reg <= cfg_data[4:0];
                REG_DMA_AMIN: dma_amin_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // input fields
    logic [1:0]  in_cmd, in_proto;
    logic        in_unit;
    logic [11:0] in_acc, in_cyc;
    assign in_cmd   = s_tdata[1:0];
    assign in_unit  = s_tdata[2];
    assign in_proto = s_tdata[4:3];
    assign in_acc   = s_tdata[16:5];
    assign in_cyc   = s_tdata[28:17];

    logic ultra;
    assign ultra = (kind_reg == KIND_ULTRA);

    // clock period, zero taken as one
    logic [DEN_W-1:0] den_cur;
    always_comb
    begin
        if (ultra)
            den_cur = (u_clk_reg == '0) ? DEN_W'(1) : u_clk_reg;
        else
            den_cur = (sys_clk_reg == '0) ? DEN_W'(1) : DEN_W'(sys_clk_reg);
    end

    logic calc_ok;
    always_comb
    begin
        unique case (kind_reg) inside
            KIND_DMA1, KIND_DMA2: calc_ok = (in_proto == PROTO_PIO) || (in_proto == PROTO_MDMA);
            KIND_ULTRA:           calc_ok = (in_proto != 2'd3);
            default:              calc_ok = 1'b0;
        endcase
    end

    logic                  s_acc;
    logic                  calc_reg;
    logic [1:0]            cmd_reg, proto_reg;
    logic [UNIT_IDX_W-1:0] uidx_reg;
    logic [11:0]           acc_ns_reg, cyc_ns_reg;
    logic [DEN_W-1:0]      d_reg;
    logic [NUM_W-1:0]      q1_reg, q2_reg;
    logic [PROD_W-1:0]     prod1_reg, prod2_reg;
    logic [31:0]           words_reg [UNITS];

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // shared divider and multiplier
    div_req_t div_req;
    div_rsp_t div_rsp;
    atwc_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    wide_t d_w, q1_w, q2_w, acc_base, acc_min, acc_raw, acc_v, m1_w;
    wide_t cyc_scaled, t2, rec_raw, rec_v, rec_base, rec_min, m2_w;
    wide_t prod1_w, prod2_w;
    logic  pio, half;
    logic [NUM_W-1:0]  num1, num2, mul_a;
    logic [PROD_W-1:0] prod;

    always_comb
    begin
        d_w     = wide_t'(d_reg);
        q1_w    = wide_t'(q1_reg);
        q2_w    = wide_t'(q2_reg);
        prod1_w = wide_t'(prod1_reg);
        prod2_w = wide_t'(prod2_reg);
        pio     = (proto_reg == PROTO_PIO);
        acc_base = pio ? wide_t'(pio_abas_reg) : wide_t'(DMA_ACCESS_BASE);
        acc_min  = pio ? wide_t'(pio_amin_reg) : wide_t'(dma_amin_reg);
        rec_base = pio ? wide_t'(pio_rbas_reg) : wide_t'(DMA_RECOVERY_BASE);
        rec_min  = pio ? wide_t'(pio_rmin_reg) : wide_t'(DMA_RECOVERY_MIN);
        acc_raw  = q1_w - acc_base;
        acc_v    = (acc_raw < acc_min) ? acc_min : acc_raw;
        m1_w     = ultra ? q1_w : acc_v + acc_base;
        // remaining cycle time after the access part (whole cycle time for UDMA)
        cyc_scaled = ultra ? wide_t'(cyc_ns_reg) * wide_t'(PS_PER_NS) : wide_t'(cyc_ns_reg);
        t2 = (proto_reg == PROTO_UDMA) ? cyc_scaled : cyc_scaled - prod1_w;
        num2 = (t2 < 0) ? '0 : NUM_W'(t2 + d_w - 1);
        rec_raw = q2_w - rec_base;
        rec_v   = (rec_raw < rec_min) ? rec_min : rec_raw;
        m2_w    = rec_v + wide_t'(DMA_RECOVERY_BASE) + acc_v + wide_t'(DMA_ACCESS_BASE);
        // half-tick DMA option
        half = (kind_reg == KIND_DMA1) && (acc_v > wide_t'(dma_amin_reg)) &&
               (prod1_w - (d_w >>> 1) >= wide_t'(acc_ns_reg)) &&
               (prod2_w - d_w >= wide_t'(cyc_ns_reg));
        if (ultra)
            num1 = NUM_W'(wide_t'(in_acc) * wide_t'(PS_PER_NS) + wide_t'(den_cur) - 1);
        else
            num1 = NUM_W'(wide_t'(in_acc) + wide_t'(den_cur) - 1);
        mul_a = (state_reg == S_MUL2) ? NUM_W'(m2_w) : NUM_W'(m1_w);
        prod  = PROD_W'(mul_a) * PROD_W'(d_reg);
    end

    always_comb
    begin
        div_req.start = (s_acc && in_cmd == CMD_CALC && calc_ok) || (state_reg == S_SUB);
        div_req.num   = (state_reg == S_SUB) ? num2 : num1;
        div_req.den   = (state_reg == S_SUB) ? d_reg : den_cur;
    end

    // result word
    logic [31:0] w_old, w_new;
    logic        ok_new;
    always_comb
    begin
        w_old  = words_reg[uidx_reg];
        w_new  = w_old;
        ok_new = 1'b1;
        if (calc_reg)
        begin
            if (!ultra && pio)
                w_new = (w_old & ~PIO_LEGACY_MASK) |
                        {21'b0, sat6(rec_v), sat5(acc_v)};
            else if (!ultra)
                w_new = (w_old & ~DMA_LEGACY_MASK) |
                        {10'b0, half, sat5(rec_v), sat5(acc_v - wide_t'(half)), 11'b0};
            else if (pio)
                w_new = (w_old & ~PIO_U66_MASK) | {22'b0, sat5(q2_w), sat5(q1_w)};
            else if (proto_reg == PROTO_MDMA)
                w_new = (w_old & ~DMA_U66_MASK) | {12'b0, sat5(q2_w), sat5(q1_w), 10'b0};
            else
                w_new = (w_old & ~UDMA_U66_MASK) |
                        {3'b0, sat4(q1_w), sat4(q2_w), 1'b1, 20'b0};
        end
        else
        begin
            case (cmd_reg)
                CMD_CALC: ok_new = 1'b0;  // unsupported pair
                CMD_NONE: ok_new = 1'b0;
                CMD_SELECT:
                begin
                    if (ultra && proto_reg == PROTO_UDMA)
                        w_new = w_old | UDMA_SELECT_BIT;
                    else if (ultra && proto_reg == PROTO_MDMA)
                        w_new = w_old & ~UDMA_SELECT_BIT;
                end
                default: ;
            endcase
        end
    end

    logic out_free;
    assign out_free = !m_tvalid || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_acc) state_next = (div_req.start) ? S_DIV1 : S_OUT;
            S_DIV1: if (div_rsp.done) state_next = S_MUL1;
            S_MUL1: state_next = S_SUB;
            S_SUB:  state_next = S_DIV2;
            S_DIV2: if (div_rsp.done) state_next = S_MUL2;
            S_MUL2: state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    logic m_valid_reg;
    logic [39:0] m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < UNITS; i++)
                words_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT && out_free)
            begin
                m_valid_reg         <= 1'b1;
                words_reg[uidx_reg] <= w_new;
            end
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            cmd_reg    <= in_cmd;
            proto_reg  <= in_proto;
            uidx_reg   <= (UNITS > 1) ? UNIT_IDX_W'(in_unit) : '0;
            acc_ns_reg <= in_acc;
            cyc_ns_reg <= in_cyc;
            d_reg      <= den_cur;
            calc_reg   <= div_req.start;
        end
        if (state_reg == S_DIV1 && div_rsp.done)
            q1_reg <= div_rsp.quo;
        if (state_reg == S_DIV2 && div_rsp.done)
            q2_reg <= div_rsp.quo;
        if (state_reg == S_MUL1)
            prod1_reg <= prod;
        if (state_reg == S_MUL2)
            prod2_reg <= prod;
        if (state_reg == S_OUT && out_free)
            m_data_reg <= {7'b0, ok_new, w_new};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- rtl/core/atwc_div.sv -----
module atwc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  atwc_pkg::div_req_t  req,
    output atwc_pkg::div_rsp_t  rsp
);
    import atwc_pkg::*;

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   rem_sh;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ----- rtl/core/atwc_checker.sv -----
`include "assert_macros.svh"

module atwc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    // one beat at a time
    `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // no result in the cycle right after a beat is taken
    `ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready, !$rose(m_tvalid))
    `ASSERT_NEXT(a_out_hold_valid, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_out_hold_data, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind ata_timing_word_calculator_core atwc_checker u_atwc_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
